>>> rtl/i2cm_pkg.sv
// Shared types, codes and helpers for the I2C master byte engine.
// No dependencies; i2cm_regs, i2cm_core and the top level import this package.
`default_nettype none
package i2cm_pkg;

  localparam int DELAY_BITS = 16;
  localparam int CFG_W      = 16;
  localparam int RECOVERY_MAX = 9;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_WRITE   = 3'd1,
    CMD_READ    = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_RECOVER = 3'd4
  } cmd_t;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_RS_SETUP  = 5'd1,
    PH_RS_WAIT   = 5'd2,
    PH_RS_HOLD   = 5'd3,
    PH_ST_SAMPLE = 5'd4,
    PH_ST_HOLD   = 5'd5,
    PH_BIT_SETUP = 5'd6,
    PH_BIT_WAIT  = 5'd7,
    PH_BIT_HOLD  = 5'd8,
    PH_SP_SETUP  = 5'd9,
    PH_SP_WAIT   = 5'd10,
    PH_SP_HOLD   = 5'd11,
    PH_SP_SAMPLE = 5'd12,
    PH_SP_END    = 5'd13,
    PH_RC_CHECK  = 5'd14,
    PH_RC_HIGH   = 5'd15,
    PH_RC_LOW    = 5'd16,
    PH_RC_SAMPLE = 5'd17
  } phase_t;

  // Register byte addresses.
  localparam logic [2:0] ADDR_HALF_PERIOD = 3'd0;
  localparam logic [CFG_W-1:0] HALF_PERIOD_RESET = 16'd156;

  typedef struct packed {
    logic [2:0] command;
    logic       with_start;
    logic       with_stop;
    logic [7:0] tx_byte;
    logic       reply_nack;
    logic       scl_level;
    logic       sda_level;
  } item_t;

  typedef struct packed {
    logic       bus_owned;
    logic       arb_lost;
    logic       nack_received;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_pull_low;
    logic       scl_pull_low;
  } result_t;

  // True when SDA is left released during the given bit slot.
  function automatic logic slot_released(input logic [3:0] bcnt, input logic rd,
                                         input logic nack, input logic [7:0] shift);
    logic rel;
    if (bcnt < 4'd8) begin
      rel = rd ? 1'b1 : shift[7];
    end else begin
      rel = rd ? nack : 1'b1;
    end
    return rel;
  endfunction

endpackage
`default_nettype wire

>>> rtl/i2cm_regs.sv
// APB-style configuration register for the I2C master byte engine.
// Holds the half-period delay; depends on i2cm_pkg.
`default_nettype none
module i2cm_regs
  import i2cm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_psel,
  input  wire logic             cfg_penable,
  input  wire logic             cfg_pwrite,
  input  wire logic [2:0]       cfg_paddr,
  input  wire logic [31:0]      cfg_pwdata,
  output logic      [31:0]      cfg_prdata,
  output logic                  cfg_pready,
  output logic      [CFG_W-1:0] half_period_o
);

  logic [CFG_W-1:0] half_period_r;
  logic             hit;

  // The low two address bits select bytes within the word and are ignored.
  assign hit = (cfg_paddr[2] == ADDR_HALF_PERIOD[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HALF_PERIOD_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && hit) begin
      half_period_r <= cfg_pwdata[CFG_W-1:0];
    end
  end

  assign cfg_pready    = 1'b1;
  assign cfg_prdata    = hit ? {{(32-CFG_W){1'b0}}, half_period_r} : 32'd0;
  assign half_period_o = half_period_r;

endmodule
`default_nettype wire

>>> rtl/i2cm_core.sv
// Bus sequencer of the I2C master byte engine: one step per bus tick.
// Holds the protocol state; depends on i2cm_pkg.
`default_nettype none
module i2cm_core
  import i2cm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step_i,
  input  wire item_t            item_i,
  input  wire logic [CFG_W-1:0] half_period_i,
  output result_t               res_o
);

  phase_t                phase_r, phase_nxt;
  logic [DELAY_BITS-1:0] dcnt_r, dcnt_nxt;
  logic [3:0]            bcnt_r, bcnt_nxt;
  logic [7:0]            shift_r, shift_nxt;
  logic                  started_r, started_nxt;
  logic                  rd_r, rd_nxt;
  logic                  stop_r, stop_nxt;
  logic                  nack_r, nack_nxt;
  logic [3:0]            pulses_r, pulses_nxt;
  logic                  drv_scl_r, drv_scl_nxt;
  logic                  drv_sda_r, drv_sda_nxt;
  logic                  st_nack_r, st_nack_nxt;
  logic                  st_arb_r, st_arb_nxt;
  logic [7:0]            rx_r, rx_nxt;
  logic                  done;

  logic [DELAY_BITS-1:0] lim;
  logic                  hit;
  logic [DELAY_BITS-1:0] dcnt_step;
  logic [3:0]            bnew;
  logic [7:0]            shift_new;
  logic                  rel;
  logic                  is_rd;

  assign lim = (DELAY_BITS'(half_period_i) == '0) ? DELAY_BITS'(1) : DELAY_BITS'(half_period_i);
  assign hit = ({1'b0, dcnt_r} + 1'b1) >= {1'b0, lim};
  assign dcnt_step = hit ? '0 : dcnt_r + 1'b1;
  assign bnew = bcnt_r + 4'd1;
  assign is_rd = (item_i.command == CMD_READ);
  assign shift_new = (item_i.command == CMD_WRITE) ? item_i.tx_byte : 8'd0;
  assign rel = slot_released(bcnt_r, rd_r, nack_r, shift_r);

  always_comb begin
    phase_nxt   = phase_r;
    dcnt_nxt    = dcnt_r;
    bcnt_nxt    = bcnt_r;
    shift_nxt   = shift_r;
    started_nxt = started_r;
    rd_nxt      = rd_r;
    stop_nxt    = stop_r;
    nack_nxt    = nack_r;
    pulses_nxt  = pulses_r;
    drv_scl_nxt = drv_scl_r;
    drv_sda_nxt = drv_sda_r;
    st_nack_nxt = st_nack_r;
    st_arb_nxt  = st_arb_r;
    rx_nxt      = rx_r;
    done        = 1'b0;

    case (phase_r)
      PH_IDLE: begin
        if (item_i.command inside {CMD_WRITE, CMD_READ, CMD_STOP, CMD_RECOVER}) begin
          dcnt_nxt   = '0;
          st_arb_nxt = 1'b0;
        end
        if (item_i.command inside {CMD_WRITE, CMD_READ}) begin
          bcnt_nxt  = 4'd0;
          rd_nxt    = is_rd;
          stop_nxt  = item_i.with_stop;
          nack_nxt  = item_i.reply_nack;
          shift_nxt = shift_new;
          if (item_i.command == CMD_WRITE && item_i.with_start) begin
            drv_sda_nxt = 1'b0;
            phase_nxt   = started_r ? PH_RS_SETUP : PH_ST_SAMPLE;
          end else begin
            drv_sda_nxt = !slot_released(4'd0, is_rd, item_i.reply_nack, shift_new);
            phase_nxt   = PH_BIT_SETUP;
          end
        end else if (item_i.command == CMD_STOP) begin
          drv_sda_nxt = 1'b1;
          phase_nxt   = PH_SP_SETUP;
        end else if (item_i.command == CMD_RECOVER) begin
          pulses_nxt  = 4'd0;
          drv_scl_nxt = 1'b0;
          drv_sda_nxt = 1'b0;
          phase_nxt   = PH_RC_CHECK;
        end
      end
      PH_RS_SETUP: begin
        dcnt_nxt = dcnt_step;
        if (hit) begin
          drv_scl_nxt = 1'b0;
          phase_nxt   = PH_RS_WAIT;
        end
      end
      PH_RS_WAIT: begin
        if (item_i.scl_level) phase_nxt = PH_RS_HOLD;
      end
      PH_RS_HOLD: begin
        dcnt_nxt = dcnt_step;
        if (hit) phase_nxt = PH_ST_SAMPLE;
      end
      PH_ST_SAMPLE: begin
        if (!item_i.sda_level) st_arb_nxt = 1'b1;
        drv_sda_nxt = 1'b1;
        phase_nxt   = PH_ST_HOLD;
      end
      PH_ST_HOLD: begin
        dcnt_nxt = dcnt_step;
        if (hit) begin
          drv_scl_nxt = 1'b1;
          started_nxt = 1'b1;
          if (bcnt_r == 4'd8 && rd_r) rx_nxt = shift_r;
          drv_sda_nxt = !rel;
          phase_nxt   = PH_BIT_SETUP;
        end
      end
      PH_BIT_SETUP: begin
        dcnt_nxt = dcnt_step;
        if (hit) begin
          drv_scl_nxt = 1'b0;
          phase_nxt   = PH_BIT_WAIT;
        end
      end
      PH_BIT_WAIT: begin
        if (item_i.scl_level) begin
          if (bcnt_r < 4'd8 && rd_r) begin
            shift_nxt = {shift_r[6:0], item_i.sda_level};
          end else if (bcnt_r < 4'd8) begin
            if (rel && !item_i.sda_level) st_arb_nxt = 1'b1;
            shift_nxt = {shift_r[6:0], 1'b0};
          end else if (rd_r) begin
            if (rel && !item_i.sda_level) st_arb_nxt = 1'b1;
          end else begin
            // Acknowledge slot after a written byte: high means NACK.
            st_nack_nxt = item_i.sda_level;
          end
          phase_nxt = PH_BIT_HOLD;
        end
      end
      PH_BIT_HOLD: begin
        dcnt_nxt = dcnt_step;
        if (hit) begin
          drv_scl_nxt = 1'b1;
          bcnt_nxt    = bnew;
          if (bnew < 4'd9) begin
            if (bnew == 4'd8 && rd_r) rx_nxt = shift_r;
            drv_sda_nxt = !slot_released(bnew, rd_r, nack_r, shift_r);
            phase_nxt   = PH_BIT_SETUP;
          end else if (stop_r) begin
            drv_sda_nxt = 1'b1;
            phase_nxt   = PH_SP_SETUP;
          end else begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end
        end
      end
      PH_SP_SETUP: begin
        dcnt_nxt = dcnt_step;
        if (hit) begin
          drv_scl_nxt = 1'b0;
          phase_nxt   = PH_SP_WAIT;
        end
      end
      PH_SP_WAIT: begin
        if (item_i.scl_level) phase_nxt = PH_SP_HOLD;
      end
      PH_SP_HOLD: begin
        dcnt_nxt = dcnt_step;
        if (hit) begin
          drv_sda_nxt = 1'b0;
          phase_nxt   = PH_SP_SAMPLE;
        end
      end
      PH_SP_SAMPLE: begin
        if (!item_i.sda_level) st_arb_nxt = 1'b1;
        phase_nxt = PH_SP_END;
      end
      PH_SP_END: begin
        dcnt_nxt = dcnt_step;
        if (hit) begin
          started_nxt = 1'b0;
          phase_nxt   = PH_IDLE;
          done        = 1'b1;
        end
      end
      PH_RC_CHECK: begin
        if (item_i.scl_level && item_i.sda_level) begin
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end else begin
          phase_nxt = PH_RC_HIGH;
        end
      end
      PH_RC_HIGH: begin
        dcnt_nxt = dcnt_step;
        if (hit) begin
          drv_scl_nxt = 1'b1;
          phase_nxt   = PH_RC_LOW;
        end
      end
      PH_RC_LOW: begin
        dcnt_nxt = dcnt_step;
        if (hit) begin
          drv_scl_nxt = 1'b0;
          drv_sda_nxt = 1'b0;
          phase_nxt   = PH_RC_SAMPLE;
        end
      end
      PH_RC_SAMPLE: begin
        pulses_nxt = pulses_r + 4'd1;
        if ((item_i.scl_level && item_i.sda_level) || (pulses_nxt >= 4'(RECOVERY_MAX))) begin
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end else begin
          phase_nxt = PH_RC_HIGH;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      dcnt_r    <= '0;
      bcnt_r    <= 4'd0;
      shift_r   <= 8'd0;
      started_r <= 1'b0;
      rd_r      <= 1'b0;
      stop_r    <= 1'b0;
      nack_r    <= 1'b0;
      pulses_r  <= 4'd0;
      drv_scl_r <= 1'b0;
      drv_sda_r <= 1'b0;
      st_nack_r <= 1'b0;
      st_arb_r  <= 1'b0;
      rx_r      <= 8'd0;
    end else if (step_i) begin
      phase_r   <= phase_nxt;
      dcnt_r    <= dcnt_nxt;
      bcnt_r    <= bcnt_nxt;
      shift_r   <= shift_nxt;
      started_r <= started_nxt;
      rd_r      <= rd_nxt;
      stop_r    <= stop_nxt;
      nack_r    <= nack_nxt;
      pulses_r  <= pulses_nxt;
      drv_scl_r <= drv_scl_nxt;
      drv_sda_r <= drv_sda_nxt;
      st_nack_r <= st_nack_nxt;
      st_arb_r  <= st_arb_nxt;
      rx_r      <= rx_nxt;
    end
  end

  // The result shows the state left behind by this tick.
  always_comb begin
    res_o.scl_pull_low  = drv_scl_nxt;
    res_o.sda_pull_low  = drv_sda_nxt;
    res_o.busy_res      = (phase_nxt != PH_IDLE);
    res_o.done_res      = done;
    res_o.rx_byte       = rx_nxt;
    res_o.nack_received = st_nack_nxt;
    res_o.arb_lost      = st_arb_nxt;
    res_o.bus_owned     = started_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/i2c_master_byte_engine.sv
// I2C master byte engine, usage summary:
// Each transaction on the in_ stream is one bus tick: the sampled SCL and SDA
// levels plus an optional command (write byte, read byte, stop, bus recovery)
// that is taken only while no operation is running. For every input
// transaction exactly one result transaction leaves on the out_ stream with
// the open-drain pull-low drives, busy and done flags, the last read byte,
// the ACK status, the arbitration flag and bus ownership.
// The input passes through one input register, then the sequencer step into the
// result register. Throughput is one transaction per cycle while the result
// receiver accepts; the sequencer state is updated once per tick.
// When the result receiver stalls, the held result and one buffered input
// wait and in_tready drops; nothing is lost or repeated.
// The half-period delay (ticks per bus delay step) is written through the cfg_ APB
// port at address 0 by the user, only while the engine is idle; the block does not check.
// Synchronous active-low reset empties both registers, releases both lines,
// returns to idle and sets the delay to 156 ticks.
// Depends on i2cm_pkg, i2cm_regs and i2cm_core.
`default_nettype none
module i2c_master_byte_engine
  import i2cm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [0] with_start, [1] with_stop, [9:2] tx_byte, [10] reply_nack,
  // [11] scl_level, [12] sda_level, [15:13] zero
  input  wire logic [15:0] in_tdata,
  // [2:0] command
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [0] scl_pull_low, [1] sda_pull_low, [2] busy_res, [3] done_res,
  // [11:4] rx_byte, [12] nack_received, [13] arb_lost,
  // [14] bus_owned, [15] zero
  output logic      [15:0] out_tdata,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  logic             in_valid_r;
  item_t            item_r;
  logic             out_valid_r;
  result_t          res_r;
  result_t          res;
  logic             step;
  logic [CFG_W-1:0] half_period;

  i2cm_regs u_regs (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready),
    .half_period_o (half_period)
  );

  // A buffered tick is processed whenever the result register is free or drains.
  assign step      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.command    <= in_tuser;
      item_r.with_start <= in_tdata[0];
      item_r.with_stop  <= in_tdata[1];
      item_r.tx_byte    <= in_tdata[9:2];
      item_r.reply_nack <= in_tdata[10];
      item_r.scl_level  <= in_tdata[11];
      item_r.sda_level  <= in_tdata[12];
    end
  end

  i2cm_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_i        (step),
    .item_i        (item_r),
    .half_period_i (half_period),
    .res_o         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r.bus_owned, res_r.arb_lost, res_r.nack_received,
                       res_r.rx_byte, res_r.done_res, res_r.busy_res, res_r.sda_pull_low,
                       res_r.scl_pull_low};

endmodule
`default_nettype wire

>>> rtl/i2cm_checker.sv
// Port-level checks for the I2C master byte engine, bound to the top level.
// Sees only the top-level ports; no package dependency.
`default_nettype none
module i2cm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata
);

  // A stalled result transaction stays offered.
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped during stall");

  // A stalled result transaction keeps its payload.
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed during stall");

  // The finishing tick always reports the engine as idle.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> !out_tdata[2])
    else $error("done reported while busy");

  // With the receiver ready the engine never back-pressures.
  a_no_stall_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("in_tready low while out_tready high");

  // Results never appear in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
